FILE: rtl/tmsm_pkg.sv
// Package: constants, state encoding and defaults for the trimmed mean stick mapper.
`timescale 1ns / 1ps

package tmsm_pkg;

   // Default sizing
   localparam int DefChannels = 4;
   localparam int DefWindow   = 8;
   localparam int DefDropLow  = 2;
   localparam int DefDropHigh = 2;
   localparam int DefKeep     = 4;

   // Field widths
   localparam int ChW   = 2;
   localparam int SmpW  = 12;
   localparam int CmdW  = 11;
   localparam int CalW  = 11;
   localparam int NumCal = 4;

   // Divider: 20-bit dividend, 11-bit divisor, one quotient bit per cycle
   localparam int DvdW = 20;
   localparam int DvsW = 11;

   // Mapping constants
   localparam logic [CmdW-1:0] CmdMin   = 11'd1100;
   localparam logic [CmdW-1:0] CmdMax   = 11'd1900;
   localparam logic [CmdW-1:0] CmdMid   = 11'd1500;
   localparam logic [SmpW-1:0] RawFloor = 12'd100;
   localparam logic [SmpW-1:0] RawTop   = 12'd3650;
   localparam logic [SmpW-1:0] DeadLo   = 12'd1775;
   localparam logic [SmpW-1:0] DeadHi   = 12'd1975;
   localparam logic [DvsW-1:0] UpperSpan = 11'd1675;
   localparam logic [CalW-1:0] CalReset = 11'h064;
   localparam logic [8:0]      CmdGain  = 9'd400;

   // Sequencer states
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_LOAD = 9'b000000010,
      S_SUM  = 9'b000000100,
      S_DIVA = 9'b000001000,
      S_MAP  = 9'b000010000,
      S_MUL  = 9'b000100000,
      S_DIVB = 9'b001000000,
      S_CMD  = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

endpackage

FILE: rtl/tmsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tmsm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: rtl/trimmed_mean_stick_mapper.sv
// Top level: per-channel window, trimmed mean and servo command mapping.
//
//  channel | dir | ports                        | payload
//  req     | in  | req_tvalid/tready/tdata[15:0] | channel, sample
//  rsp     | out | rsp_tvalid/tready/tdata[31:0] | out_channel, filtered, command
//  csr     | in  | csr_we/csr_index/csr_wdata   | low_cal_ch0..3
//
// A sample that does not finish its window is only written to RAM. A sample
// that finishes one has its window read into the insertion sorter and its
// kept ranks summed and divided by KEEP in the shared bit-serial divider;
// the mean is then mapped to a command, with a second divider pass unless
// it lies in the dead band or is clamped. Reset is synchronous, clears the
// fill counts and sets the calibrations to 100. A stalled result holds its
// register and the input stays not ready until it is taken.
`timescale 1ns / 1ps

module trimmed_mean_stick_mapper
   import tmsm_pkg::*;
#(
   parameter int CHANNELS  = DefChannels,
   parameter int WINDOW    = DefWindow,
   parameter int DROP_LOW  = DefDropLow,
   parameter int DROP_HIGH = DefDropHigh,
   parameter int KEEP      = DefKeep
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [1:0] channel, [13:2] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] out_channel, [13:2] filtered, [24:14] command
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [CalW-1:0] csr_wdata
);

   localparam int Depth  = CHANNELS * WINDOW;
   localparam int AW     = $clog2(Depth);
   localparam int FW     = $clog2(WINDOW);
   localparam int CW     = $clog2(WINDOW + 1);
   localparam int SW     = $clog2(WINDOW) + SmpW;
   localparam int SumEnd = (DROP_LOW + KEEP < WINDOW) ? DROP_LOW + KEEP : WINDOW;
   localparam int DivLast = DvdW - 1;
   // trimmed ranks end before the top DROP_HIGH when KEEP is consistent
   localparam int TopRank = WINDOW - DROP_HIGH;

   state_type state_ff, state_in;

   logic [CalW-1:0] cal_ff [NumCal];
   logic [FW-1:0]   fill_ff [CHANNELS];
   logic [FW-1:0]   fill_in [CHANNELS];
   logic [SmpW-1:0] s_ff [WINDOW];
   logic [SmpW-1:0] s_in [WINDOW];

   logic [ChW-1:0]  ch_ff, ch_in;
   logic [AW-1:0]   base_ff, base_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [SW-1:0]   acc_ff, acc_in;
   logic [DvdW-1:0] dq_ff, dq_in;
   logic [DvsW-1:0] rem_ff, rem_in;
   logic [DvsW-1:0] dvs_ff, dvs_in;
   logic [4:0]      dcnt_ff, dcnt_in;
   logic [SmpW-1:0] avg_ff, avg_in;
   logic [SmpW-1:0] diff_ff, diff_in;
   logic            lower_ff, lower_in;
   logic [CmdW-1:0] cmd_ff, cmd_in;

   logic [ChW-1:0]  req_ch;
   logic [SmpW-1:0] req_smp;
   logic            ch_ok;
   logic [FW-1:0]   cur_fill;
   logic            ram_we;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [SmpW-1:0] ram_rdata;

   logic [DvsW:0]   div_t;
   logic            div_ge;
   logic [DvsW-1:0] div_rem;
   logic [DvdW-1:0] div_dq;
   logic [CalW-1:0] cal_sel;
   logic [SmpW-1:0] avg_w;
   logic [CmdW-1:0] lower_cmd;

   assign req_ch  = req_tdata[1:0];
   assign req_smp = req_tdata[13:2];
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {7'd0, cmd_ff, avg_ff, ch_ff};

   // channel lookup of the fill count
   always_comb begin
      ch_ok    = (int'(req_ch) < CHANNELS);
      cur_fill = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (int'(req_ch) == i) begin
            cur_fill = fill_ff[i];
         end
      end
   end

   // window RAM
   assign ram_we    = req_tvalid && req_tready && ch_ok;
   assign ram_waddr = AW'(int'(req_ch) * WINDOW + int'(cur_fill));
   assign ram_raddr = base_ff + AW'(cnt_ff);

   tmsm_ram #(
      .WIDTH (SmpW),
      .DEPTH (Depth)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_smp),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared restoring divider step
   always_comb begin
      div_t   = {rem_ff, dq_ff[DvdW-1]};
      div_ge  = (div_t >= {1'b0, dvs_ff});
      div_rem = div_ge ? DvsW'(div_t - {1'b0, dvs_ff}) : div_t[DvsW-1:0];
      div_dq  = {dq_ff[DvdW-2:0], div_ge};
   end

   assign cal_sel = cal_ff[ch_ff];
   assign avg_w   = dq_ff[SmpW-1:0];
   assign lower_cmd = (dq_ff[CmdW-1:0] + CmdMin > CmdMid) ? CmdMid
                                                         : dq_ff[CmdW-1:0] + CmdMin;

   // sequencer
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      s_in     = s_ff;
      ch_in    = ch_ff;
      base_in  = base_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      dq_in    = dq_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      dcnt_in  = dcnt_ff;
      avg_in   = avg_ff;
      diff_in  = diff_ff;
      lower_in = lower_ff;
      cmd_in   = cmd_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && ch_ok) begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (int'(req_ch) == i) begin
                     if (cur_fill == FW'(WINDOW - 1)) begin
                        fill_in[i] = '0;
                     end else begin
                        fill_in[i] = cur_fill + 1'b1;
                     end
                  end
               end
               if (cur_fill == FW'(WINDOW - 1)) begin
                  ch_in    = req_ch;
                  base_in  = AW'(int'(req_ch) * WINDOW);
                  cnt_in   = '0;
                  for (int i = 0; i < WINDOW; i++) begin
                     s_in[i] = '1;
                  end
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            // insertion sorter: each cell decides on its own
            if (cnt_ff != '0) begin
               for (int i = 0; i < WINDOW; i++) begin
                  if (ram_rdata < s_ff[i]) begin
                     if (i == 0) begin
                        s_in[i] = ram_rdata;
                     end else if (ram_rdata >= s_ff[i-1]) begin
                        s_in[i] = ram_rdata;
                     end else begin
                        s_in[i] = s_ff[i-1];
                     end
                  end
               end
            end
            if (cnt_ff == CW'(WINDOW)) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = S_SUM;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_SUM: begin
            // shift ranks down and add the kept ones
            for (int i = 0; i < WINDOW - 1; i++) begin
               s_in[i] = s_ff[i+1];
            end
            if (int'(cnt_ff) >= DROP_LOW && int'(cnt_ff) < SumEnd) begin
               acc_in = acc_ff + SW'(s_ff[0]);
            end
            if (cnt_ff == CW'(WINDOW - 1)) begin
               dq_in    = DvdW'(acc_in);
               rem_in   = '0;
               dvs_in   = DvsW'(KEEP);
               dcnt_in  = '0;
               state_in = S_DIVA;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_DIVA, S_DIVB: begin
            dq_in   = div_dq;
            rem_in  = div_rem;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 5'(DivLast)) begin
               state_in = (state_ff == S_DIVA) ? S_MAP : S_CMD;
            end
         end
         S_MAP: begin
            avg_in   = avg_w;
            state_in = S_OUT;
            if (avg_w >= DeadLo && avg_w <= DeadHi) begin
               cmd_in = CmdMid;
            end else if (avg_w < DeadLo) begin
               if (avg_w <= RawFloor || cal_sel >= CalW'(DeadLo)
                   || avg_w <= SmpW'(cal_sel)) begin
                  cmd_in = CmdMin;
               end else begin
                  diff_in  = avg_w - SmpW'(cal_sel);
                  dvs_in   = DvsW'(DeadLo) - cal_sel;
                  lower_in = 1'b1;
                  state_in = S_MUL;
               end
            end else if (avg_w >= RawTop) begin
               cmd_in = CmdMax;
            end else begin
               diff_in  = avg_w - DeadHi;
               dvs_in   = UpperSpan;
               lower_in = 1'b0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            dq_in    = DvdW'(diff_ff) * DvdW'(CmdGain);
            rem_in   = '0;
            dcnt_in  = '0;
            state_in = S_DIVB;
         end
         S_CMD: begin
            cmd_in   = lower_ff ? lower_cmd : dq_ff[CmdW-1:0] + CmdMid;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < CHANNELS; i++) begin
            fill_ff[i] <= '0;
         end
         for (int i = 0; i < NumCal; i++) begin
            cal_ff[i] <= CalReset;
         end
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (csr_we) begin
            cal_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      s_ff     <= s_in;
      ch_ff    <= ch_in;
      base_ff  <= base_in;
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      dcnt_ff  <= dcnt_in;
      avg_ff   <= avg_in;
      diff_ff  <= diff_in;
      lower_ff <= lower_in;
      cmd_ff   <= cmd_in;
   end

   // checks
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cmd_ff >= CmdMin && cmd_ff <= CmdMax))
      else $error("command out of range");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVA && dcnt_ff == 5'(DivLast)) |=> (state_ff == S_MAP))
      else $error("average divide did not hand over to mapping");

   a_rank_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |-> (SumEnd <= WINDOW && DROP_LOW <= TopRank + KEEP))
      else $error("kept ranks beyond window");

endmodule
